// ===== src/anmr_pkg.sv =====
package anmr_pkg;

    // field widths
    localparam int CHAR_BITS  = 8;
    localparam int COUNT_BITS = 32;
    localparam int OUT_COUNT_BITS = 32;
    localparam int REM_BITS   = 63;
    localparam int REM_PROD_BITS = REM_BITS + 5;
    localparam int COUNT_PROD_BITS = COUNT_BITS + 5;
    localparam int OUT_DATA_BITS = ((OUT_COUNT_BITS + REM_BITS + 7) / 8) * 8;

    // 2^63-1, the modulus of the remainder part
    localparam logic [REM_BITS-1:0] REM_MOD = '1;

    // character codes
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_A_LO  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_F_LO  = 8'h66;
    localparam logic [CHAR_BITS-1:0] CHAR_A_UP  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_F_UP  = 8'h46;
    localparam logic [CHAR_BITS-1:0] CHAR_X_LO  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_X_UP  = 8'h58;

    // digit decode result: bit 4 set means no digit
    typedef logic [4:0] digit_t;
    localparam digit_t DIGIT_NONE = 5'd16;
    localparam digit_t DIGIT_TEN  = 5'd10;

    // character position within the numeral, saturates at the third
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_LATER  = 2'd2
    } char_pos_t;

    function automatic digit_t decode_digit(input logic [CHAR_BITS-1:0] c);
        digit_t d;
        d = DIGIT_NONE;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = digit_t'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_A_LO && c <= CHAR_F_LO)
        begin
            d = digit_t'(c - CHAR_A_LO) + DIGIT_TEN;
        end
        else if (c >= CHAR_A_UP && c <= CHAR_F_UP)
        begin
            d = digit_t'(c - CHAR_A_UP) + DIGIT_TEN;
        end
        return d;
    endfunction

endpackage

// ===== src/ascii_number_to_mixed_radix.sv =====
// Parses an ASCII numeral, one character per transfer with tlast on its final
// character, into count * (2^63-1) + remainder. A leading "0x" or "0X" selects
// hexadecimal, otherwise the digits are decimal. One result transfer comes per
// numeral, on its last character: tuser is 1 for a valid numeral, and 0 (with
// zero data) for a bad digit, a hex letter in decimal mode, a prefix without
// digits, or a count that passes 32 bits. One character is taken every cycle,
// except while a last character waits for a stalled result; a character is
// held in the input register while the multiply-by-base and Mersenne fold
// run, and a last character's result is then stored in the result register.
// That combinational accumulate step (63-bit times 10 or 16, fold add and
// compare) sets the clock rate.
module ascii_number_to_mixed_radix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [anmr_pkg::CHAR_BITS-1:0]      s_axis_tdata,  // char_code
    input  logic                                s_axis_tlast,  // is_last
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [anmr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // count_part, remainder_part, pad
    output logic                                m_axis_tuser   // ok
);
    import anmr_pkg::*;

    // input register
    logic                  in_valid_reg;
    logic [CHAR_BITS-1:0]  in_char_reg;
    logic                  in_last_reg;

    // accumulator state
    logic [COUNT_BITS-1:0] count_acc_reg, count_acc_next;
    logic [REM_BITS-1:0]   rem_acc_reg, rem_acc_next;
    logic                  hex_mode_reg, hex_mode_next;
    char_pos_t             pos_reg, pos_next;
    logic                  first_zero_reg, first_zero_next;
    logic                  digit_seen_reg, digit_seen_next;
    logic                  failed_reg, failed_next;

    // result register
    logic                      out_valid_reg;
    logic [OUT_COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic [REM_BITS-1:0]       out_rem_reg, out_rem_next;
    logic                      out_ok_reg, out_ok_next;

    logic out_free;
    logic advance;
    logic emit;

    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign emit          = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // digit classification
    digit_t d;
    logic   is_prefix;
    logic   bad_char;

    assign d         = decode_digit(in_char_reg);
    assign is_prefix = (pos_reg == POS_SECOND) && first_zero_reg &&
                       (in_char_reg == CHAR_X_LO || in_char_reg == CHAR_X_UP);
    assign bad_char  = d[4] || (d >= DIGIT_TEN && !hex_mode_reg);

    // remainder times base plus digit, folded modulo 2^63-1
    logic [REM_PROD_BITS-1:0] rem_prod;
    logic [4:0]               fold_hi;
    logic [REM_BITS:0]        fold_sum;
    logic                     fold_wrap;
    logic [REM_BITS-1:0]      rem_new;
    logic [4:0]               carry;

    always_comb
    begin
        if (hex_mode_reg)
        begin
            rem_prod = {1'b0, rem_acc_reg, 4'b0000};
        end
        else
        begin
            rem_prod = {2'b00, rem_acc_reg, 3'b000} + {4'b0000, rem_acc_reg, 1'b0};
        end
        rem_prod  = rem_prod + REM_PROD_BITS'(d[3:0]);
        fold_hi   = rem_prod[REM_PROD_BITS-1:REM_BITS];
        fold_sum  = {1'b0, rem_prod[REM_BITS-1:0]} + (REM_BITS + 1)'(fold_hi);
        fold_wrap = fold_sum >= {1'b0, REM_MOD};
        if (fold_wrap)
        begin
            rem_new = REM_BITS'(fold_sum - {1'b0, REM_MOD});
            carry   = fold_hi + 5'd1;
        end
        else
        begin
            rem_new = fold_sum[REM_BITS-1:0];
            carry   = fold_hi;
        end
    end

    // count times base plus carry, overflow past COUNT_BITS
    logic [COUNT_PROD_BITS-1:0] count_prod;
    logic                       count_ovf;

    always_comb
    begin
        if (hex_mode_reg)
        begin
            count_prod = {1'b0, count_acc_reg, 4'b0000};
        end
        else
        begin
            count_prod = {2'b00, count_acc_reg, 3'b000} + {4'b0000, count_acc_reg, 1'b0};
        end
        count_prod = count_prod + COUNT_PROD_BITS'(carry);
        count_ovf  = |count_prod[COUNT_PROD_BITS-1:COUNT_BITS];
    end

    // state update and result formation
    always_comb
    begin
        count_acc_next  = count_acc_reg;
        rem_acc_next    = rem_acc_reg;
        hex_mode_next   = hex_mode_reg;
        pos_next        = pos_reg;
        first_zero_next = first_zero_reg;
        digit_seen_next = digit_seen_reg;
        failed_next     = failed_reg;
        out_count_next  = '0;
        out_rem_next    = '0;
        out_ok_next     = 1'b0;

        if (is_prefix)
        begin
            hex_mode_next   = 1'b1;
            digit_seen_next = 1'b0;
        end
        else if (bad_char)
        begin
            failed_next = 1'b1;
        end
        else if (!failed_reg)
        begin
            if (count_ovf)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                count_acc_next = count_prod[COUNT_BITS-1:0];
                rem_acc_next   = rem_new;
            end
            digit_seen_next = 1'b1;
        end

        if (pos_reg == POS_FIRST)
        begin
            first_zero_next = (in_char_reg == CHAR_ZERO);
        end
        unique case (pos_reg)
            POS_FIRST:  pos_next = POS_SECOND;
            POS_SECOND: pos_next = POS_LATER;
            default:    pos_next = POS_LATER;
        endcase

        if (in_last_reg)
        begin
            if (!failed_next && digit_seen_next)
            begin
                out_count_next = OUT_COUNT_BITS'(count_acc_next);
                out_rem_next   = rem_acc_next;
                out_ok_next    = 1'b1;
            end
            count_acc_next  = '0;
            rem_acc_next    = '0;
            hex_mode_next   = 1'b0;
            pos_next        = POS_FIRST;
            first_zero_next = 1'b0;
            digit_seen_next = 1'b0;
            failed_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_acc_reg  <= '0;
            rem_acc_reg    <= '0;
            hex_mode_reg   <= 1'b0;
            pos_reg        <= POS_FIRST;
            first_zero_reg <= 1'b0;
            digit_seen_reg <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            count_acc_reg  <= count_acc_next;
            rem_acc_reg    <= rem_acc_next;
            hex_mode_reg   <= hex_mode_next;
            pos_reg        <= pos_next;
            first_zero_reg <= first_zero_next;
            digit_seen_reg <= digit_seen_next;
            failed_reg     <= failed_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_count_reg <= out_count_next;
            out_rem_reg   <= out_rem_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_rem_reg, out_count_reg});
    assign m_axis_tuser  = out_ok_reg;

    // a failed numeral carries zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("failed result with nonzero data");

    // the remainder stays below 2^63-1
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_acc_reg != REM_MOD)
        else $error("remainder accumulator reached the modulus");

    // the numeral state returns to reset after its last character
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> count_acc_reg == '0 && rem_acc_reg == '0 && pos_reg == POS_FIRST &&
                 !hex_mode_reg && !failed_reg && !digit_seen_reg)
        else $error("state not cleared after last character");

    // a processed last character always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_axis_tvalid)
        else $error("result lost");

endmodule

// ===== test/tb_ascii_number_to_mixed_radix.sv =====
module tb_ascii_number_to_mixed_radix;

    import anmr_pkg::*;

    // one parsed numeral as it leaves the block
    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] count;
        logic [REM_BITS-1:0]       rem;
        logic                      ok;
    } numeral_val_t;

    // one character of the directed table, with an optional hand-written result
    typedef struct packed {
        logic [CHAR_BITS-1:0] c;
        logic                 last;
        logic                 typed;
        numeral_val_t         val;
    } char_row_t;

    localparam numeral_val_t REJECTED = '0;
    localparam numeral_val_t NO_VAL   = '0;
    localparam int N_ROWS       = 27;
    localparam int RANDOM_CHARS = 1300;
    localparam int QUIET_CHARS  = 1100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [CHAR_BITS-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tuser;

    // parser shadow state
    logic [COUNT_BITS-1:0] cnt_acc;
    logic [REM_BITS-1:0]   rem_acc;
    logic                  hex_mode;
    logic                  first_zero;
    logic                  digit_seen;
    logic                  parse_failed;
    char_pos_t             char_pos;

    numeral_val_t pending_vals[$];
    logic [CHAR_BITS-1:0] numeral_txt[$];

    logic idle_on = 1'b1;
    int ready_hold = 0;
    int n_chars = 0;
    int n_numerals = 0;
    int n_results = 0;
    int n_good = 0;
    int n_errors = 0;

    char_row_t dir_rows [N_ROWS] = '{
        '{CHAR_ZERO, 1'b1, 1'b1, '{32'd0, 63'd0, 1'b1}},   // lone zero
        '{CHAR_ZERO, 1'b0, 1'b0, NO_VAL},
        '{CHAR_X_LO, 1'b1, 1'b1, REJECTED},                // prefix with no digit
        '{CHAR_ZERO, 1'b0, 1'b0, NO_VAL},
        '{CHAR_X_UP, 1'b0, 1'b0, NO_VAL},
        '{CHAR_F_UP, 1'b1, 1'b1, '{32'd0, 63'd15, 1'b1}},  // upper-case hex digit
        '{CHAR_ZERO, 1'b0, 1'b0, NO_VAL},
        '{CHAR_X_LO, 1'b0, 1'b0, NO_VAL},
        '{CHAR_A_LO, 1'b1, 1'b0, NO_VAL},
        '{CHAR_A_LO, 1'b1, 1'b1, REJECTED},                // hex letter in decimal
        '{8'h00,     1'b1, 1'b1, REJECTED},                // nul
        '{8'hFF,     1'b1, 1'b1, REJECTED},
        '{CHAR_X_LO, 1'b1, 1'b1, REJECTED},                // x as first character
        '{CHAR_NINE, 1'b1, 1'b1, '{32'd0, 63'd9, 1'b1}},
        '{CHAR_ZERO, 1'b0, 1'b0, NO_VAL},                  // leading zero, decimal
        '{8'h37,     1'b1, 1'b0, NO_VAL},
        '{8'h31,     1'b0, 1'b0, NO_VAL},
        '{CHAR_X_UP, 1'b1, 1'b1, REJECTED},                // x after a nonzero digit
        '{8'h31,     1'b0, 1'b0, NO_VAL},
        '{8'h32,     1'b0, 1'b0, NO_VAL},
        '{8'h2F,     1'b0, 1'b0, NO_VAL},                  // just below '0', mid numeral
        '{8'h35,     1'b1, 1'b1, REJECTED},
        '{CHAR_ZERO, 1'b0, 1'b0, NO_VAL},
        '{CHAR_X_LO, 1'b0, 1'b0, NO_VAL},
        '{8'h47,     1'b1, 1'b1, REJECTED},                // 'G' in hex mode
        '{8'h60,     1'b1, 1'b1, REJECTED},                // just below 'a'
        '{8'h3A,     1'b1, 1'b1, REJECTED}                 // just above '9'
    };

    ascii_number_to_mixed_radix DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic digit_t digit_value(input logic [CHAR_BITS-1:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            return {1'b0, c[3:0]};
        end
        if ((c >= CHAR_A_LO && c <= CHAR_F_LO) || (c >= CHAR_A_UP && c <= CHAR_F_UP))
        begin
            return {1'b0, c[3:0]} + 5'd9;
        end
        return DIGIT_NONE;
    endfunction

    function automatic logic [CHAR_BITS-1:0] hex_glyph(input int v, input bit upper);
        if (v < 10)
        begin
            return CHAR_ZERO + CHAR_BITS'(v);
        end
        return (upper ? CHAR_A_UP : CHAR_A_LO) + CHAR_BITS'(v - 10);
    endfunction

    task automatic clear_numeral();
        cnt_acc      = '0;
        rem_acc      = '0;
        hex_mode     = 1'b0;
        first_zero   = 1'b0;
        digit_seen   = 1'b0;
        parse_failed = 1'b0;
        char_pos     = POS_FIRST;
    endtask

    // advance the shadow parser by one character, queue a result on the last one
    task automatic absorb_char(input logic [CHAR_BITS-1:0] c, input logic last,
                               input logic typed, input numeral_val_t typed_val);
        digit_t d;
        logic [4:0] radix;
        logic [REM_BITS+4:0] prod;
        logic [63:0] wide_cnt;
        numeral_val_t v;
        if (char_pos == POS_SECOND && first_zero && (c == CHAR_X_LO || c == CHAR_X_UP))
        begin
            hex_mode   = 1'b1;
            digit_seen = 1'b0;
        end
        else
        begin
            d = digit_value(c);
            if (d == DIGIT_NONE || (d >= DIGIT_TEN && !hex_mode))
            begin
                parse_failed = 1'b1;
            end
            else if (!parse_failed)
            begin
                // value * radix + digit, folded modulo 2^63-1 into the count
                radix = hex_mode ? 5'd16 : 5'd10;
                prod = (REM_BITS+5)'(rem_acc) * (REM_BITS+5)'(radix) + (REM_BITS+5)'(d);
                wide_cnt = 64'(cnt_acc) * 64'(radix) + 64'(prod / (REM_BITS+5)'(REM_MOD));
                if (wide_cnt[63:COUNT_BITS] != '0)
                begin
                    parse_failed = 1'b1;
                end
                else
                begin
                    cnt_acc = wide_cnt[COUNT_BITS-1:0];
                    rem_acc = REM_BITS'(prod % (REM_BITS+5)'(REM_MOD));
                end
                digit_seen = 1'b1;
            end
        end
        if (char_pos == POS_FIRST)
        begin
            first_zero = (c == CHAR_ZERO);
        end
        if (char_pos != POS_LATER)
        begin
            char_pos = char_pos_t'(char_pos + 2'd1);
        end
        if (last)
        begin
            v = '0;
            if (!parse_failed && digit_seen)
            begin
                v.count = OUT_COUNT_BITS'(cnt_acc);
                v.rem   = rem_acc;
                v.ok    = 1'b1;
            end
            pending_vals.push_back(typed ? typed_val : v);
            n_numerals++;
            clear_numeral();
        end
    endtask

    // offer one character, with an occasional idle burst first
    task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic last,
                             input logic typed, input numeral_val_t typed_val);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        absorb_char(c, last, typed, typed_val);
        n_chars++;
    endtask

    // build one random numeral text: well-formed mostly, some near the top, some broken
    task automatic make_numeral();
        int kind;
        int len;
        int k;
        bit is_hex;
        string top_digits;
        numeral_txt.delete();
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            // noise bytes
            len = $urandom_range(1, 5);
            repeat (len) numeral_txt.push_back(CHAR_BITS'($urandom_range(0, 255)));
        end
        else if (kind < 4)
        begin
            // around the largest value that still fits
            k = $urandom_range(0, 3);
            if (k == 3)
            begin
                len = $urandom_range(28, 30);
                top_digits = "39614081";
                foreach (top_digits[i]) numeral_txt.push_back(top_digits[i]);
                repeat (len - 8) numeral_txt.push_back(CHAR_ZERO + CHAR_BITS'($urandom_range(0, 9)));
            end
            else
            begin
                numeral_txt.push_back(CHAR_ZERO);
                numeral_txt.push_back($urandom_range(0, 1) ? CHAR_X_UP : CHAR_X_LO);
                len = (k == 2) ? $urandom_range(0, 8) : 0;
                for (int i = 0; i < 24; i++)
                begin
                    if (i >= 24 - len)
                        numeral_txt.push_back(hex_glyph($urandom_range(0, 15),
                                                        1'($urandom_range(0, 1))));
                    else if (i == 0)
                        numeral_txt.push_back(hex_glyph(7, 1'b1));
                    else if (i < 15)
                        numeral_txt.push_back(hex_glyph(15, 1'($urandom_range(0, 1))));
                    else if (i == 15)
                        numeral_txt.push_back(hex_glyph(k == 1 ? 15 : 14, 1'b1));
                    else
                        numeral_txt.push_back(hex_glyph(k == 1 ? 0 : 15, 1'b0));
                end
            end
        end
        else
        begin
            is_hex = 1'($urandom_range(0, 1));
            len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 20);
            if (is_hex)
            begin
                numeral_txt.push_back(CHAR_ZERO);
                numeral_txt.push_back($urandom_range(0, 1) ? CHAR_X_UP : CHAR_X_LO);
                repeat (len) numeral_txt.push_back(hex_glyph($urandom_range(0, 15),
                                                             1'($urandom_range(0, 1))));
            end
            else
            begin
                repeat (len) numeral_txt.push_back(CHAR_ZERO + CHAR_BITS'($urandom_range(0, 9)));
            end
            // break some of them
            if (kind < 7)
            begin
                k = $urandom_range(0, numeral_txt.size() - 1);
                case ($urandom_range(0, 2))
                    0: numeral_txt[k] = CHAR_BITS'($urandom_range(0, 255));
                    1:
                    begin
                        if (is_hex)
                            while (numeral_txt.size() > 2) void'(numeral_txt.pop_back());
                        else
                            numeral_txt[k] = hex_glyph($urandom_range(10, 15),
                                                       1'($urandom_range(0, 1)));
                    end
                    default: numeral_txt.push_back(CHAR_BITS'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // output side stalls
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold <= $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [REM_BITS-1:0] want,
                               input logic [REM_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // result transfers against the oldest pending value
    always @(posedge clk)
    begin
        numeral_val_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_vals.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h ok %b",
                         $time, m_axis_tdata, m_axis_tuser);
                n_errors++;
            end
            else
            begin
                want = pending_vals.pop_front();
                check_field("count_part", REM_BITS'(want.count),
                            REM_BITS'(m_axis_tdata[OUT_COUNT_BITS-1:0]));
                check_field("remainder_part", want.rem,
                            m_axis_tdata[OUT_COUNT_BITS +: REM_BITS]);
                check_field("ok", REM_BITS'(want.ok), REM_BITS'(m_axis_tuser));
            end
            n_results++;
            if (m_axis_tuser)
            begin
                n_good++;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results pending", pending_vals.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int start_chars;
        clear_numeral();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_ROWS; i++)
        begin
            send_char(dir_rows[i].c, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].val);
        end

        // random numerals, no idling toward the end
        start_chars = n_chars;
        while (n_chars - start_chars < RANDOM_CHARS)
        begin
            idle_on = (n_chars - start_chars < QUIET_CHARS) && ($urandom_range(0, 3) != 0);
            make_numeral();
            foreach (numeral_txt[i])
            begin
                send_char(numeral_txt[i], i == numeral_txt.size() - 1, 1'b0, NO_VAL);
            end
        end
        idle_on = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_vals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("%0d characters in %0d numerals sent, %0d results checked (%0d valid)",
                 n_chars, n_numerals, n_results, n_good);
        $display("decimal, hex, near-overflow and broken numerals, %0d mismatches", n_errors);
        if (n_errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
